FILE: hdl/lru_pkg.sv
package lru_pkg;

  localparam int IDX_W     = 4;
  localparam int CMD_W     = 3;
  localparam int TIME_W    = 32;
  localparam int STAT_W    = 2;
  localparam int BUDGET_W  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_SLOTS = 16;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PIN    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NUKE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RELOAD = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_VICTIM = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_LIMIT   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_SHIFT,
    S_RESPOND
  } lru_state_t;

  typedef enum logic [1:0] {
    ORD_NOP,
    ORD_APPEND,
    ORD_WRITE,
    ORD_DROP
  } ord_op_t;

  typedef struct packed {
    ord_op_t          op;
    logic [IDX_W-1:0] rd_pos;
    logic [IDX_W-1:0] wr_pos;
    logic [IDX_W-1:0] wr_slot;
  } ord_ctl_t;

endpackage

FILE: hdl/lru_order.sv
module lru_order import lru_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int CNT_W  = $clog2(SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  ord_ctl_t          ctl,
  output logic [SLOT_W-1:0] rd_slot,
  output logic [CNT_W-1:0]  count
);

  // list order, oldest at position 0
  logic [SLOT_W-1:0] order [SLOTS];

  assign rd_slot = order[ctl.rd_pos[SLOT_W-1:0]];

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      ORD_APPEND: order[count[SLOT_W-1:0]] <= ctl.wr_slot[SLOT_W-1:0];
      ORD_WRITE:  order[ctl.wr_pos[SLOT_W-1:0]] <= ctl.wr_slot[SLOT_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctl.op)
        ORD_APPEND: count <= count + CNT_W'(1);
        ORD_DROP:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/lru_ctrl.sv
module lru_ctrl import lru_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int CNT_W  = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [TIME_W-1:0]   in_time_now,
  input  logic                in_pin_value,
  input  logic [TIME_W-1:0]   touch_interval,
  input  logic [BUDGET_W-1:0] budget_limit,
  output ord_ctl_t            ord_ctl,
  input  logic [SLOT_W-1:0]   rd_slot,
  input  logic [CNT_W-1:0]    count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [IDX_W-1:0]    out_victim
);

  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(SLOTS);

  lru_state_t state, state_next;

  logic [CMD_W-1:0]    cur_cmd;
  logic [IDX_W-1:0]    cur_idx;
  logic [TIME_W-1:0]   cur_time;
  logic                cur_pin;
  logic [SLOT_W-1:0]   ptr;
  logic [SLOT_W-1:0]   hold_slot;
  logic [BUDGET_W-1:0] budget;
  logic [STAT_W-1:0]   res_status;
  logic [IDX_W-1:0]    res_victim;

  logic                on_list [SLOTS];
  logic                pinned  [SLOTS];
  logic [TIME_W-1:0]   stamp   [SLOTS];

  logic                idx_ok;
  logic [SLOT_W-1:0]   slot;
  logic                listed;
  logic [TIME_W-1:0]   age;
  logic                touch_ok;
  logic                is_match;
  logic                last_pos;
  logic                load_out;

  assign idx_ok   = {1'b0, cur_idx} < IDX_LIMIT;
  assign slot     = cur_idx[SLOT_W-1:0];
  assign listed   = idx_ok && on_list[slot];
  // wrapping tick counter, so the age is taken modulo 2^32
  assign age      = cur_time - stamp[slot];
  assign touch_ok = age >= touch_interval;
  assign is_match = (cur_cmd == CMD_NUKE) ? !pinned[rd_slot] : (rd_slot == slot);
  assign last_pos = (CNT_W'(ptr) + CNT_W'(1)) == count;
  assign load_out = (state == S_RESPOND) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        state_next = S_RESPOND;
        case (cur_cmd)
          CMD_REMOVE: if (listed) state_next = S_SEARCH;
          CMD_TOUCH:  if (listed && touch_ok) state_next = S_SEARCH;
          CMD_NUKE:   if (budget != '0 && count != '0) state_next = S_SEARCH;
          default: ;
        endcase
      end
      S_SEARCH:
        if (is_match) state_next = S_SHIFT;
        else if (last_pos) state_next = S_RESPOND;
      S_SHIFT:
        if (last_pos) state_next = S_RESPOND;
      S_RESPOND:
        if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == S_IDLE);
    ord_ctl.op      = ORD_NOP;
    ord_ctl.rd_pos  = IDX_W'(ptr);
    ord_ctl.wr_pos  = IDX_W'(ptr);
    ord_ctl.wr_slot = cur_idx;
    unique case (state)
      S_CHECK:
        if (cur_cmd == CMD_ADD && idx_ok && !on_list[slot]) ord_ctl.op = ORD_APPEND;
      S_SHIFT: begin
        // close the gap one position per cycle, then finish at the newest end
        ord_ctl.rd_pos = IDX_W'(ptr) + IDX_W'(1);
        if (!last_pos) begin
          ord_ctl.op      = ORD_WRITE;
          ord_ctl.wr_slot = IDX_W'(rd_slot);
        end else if (cur_cmd == CMD_REMOVE) begin
          ord_ctl.op = ORD_DROP;
        end else begin
          ord_ctl.op      = ORD_WRITE;
          ord_ctl.wr_slot = IDX_W'(hold_slot);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      budget    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        on_list[i] <= 1'b0;
        pinned[i]  <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == S_CHECK) begin
        case (cur_cmd)
          CMD_ADD:    if (idx_ok && !on_list[slot]) on_list[slot] <= 1'b1;
          CMD_REMOVE: if (listed) on_list[slot] <= 1'b0;
          CMD_PIN:    if (idx_ok) pinned[slot] <= cur_pin;
          CMD_NUKE:   if (budget != '0) budget <= budget - BUDGET_W'(1);
          CMD_RELOAD: budget <= budget_limit;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_cmd  <= in_command;
      cur_idx  <= in_entry_index;
      cur_time <= in_time_now;
      cur_pin  <= in_pin_value;
    end
    if (load_out) begin
      out_status <= res_status;
      out_victim <= res_victim;
    end
    unique case (state)
      S_CHECK: begin
        ptr        <= '0;
        res_victim <= '0;
        case (cur_cmd)
          CMD_ADD:
            if (idx_ok && !on_list[slot]) begin
              stamp[slot] <= cur_time;
              res_status  <= ST_DONE;
            end else begin
              res_status  <= ST_IGNORED;
            end
          CMD_REMOVE:
            res_status <= listed ? ST_DONE : ST_IGNORED;
          CMD_TOUCH:
            if (listed && touch_ok) begin
              stamp[slot] <= cur_time;
              res_status  <= ST_DONE;
            end else begin
              res_status  <= ST_IGNORED;
            end
          CMD_PIN:
            res_status <= idx_ok ? ST_DONE : ST_IGNORED;
          CMD_NUKE:
            res_status <= (budget == '0) ? ST_EXHAUSTED : ST_NO_VICTIM;
          CMD_RELOAD:
            res_status <= ST_DONE;
          default:
            res_status <= ST_IGNORED;
        endcase
      end
      S_SEARCH:
        if (is_match) begin
          hold_slot <= rd_slot;
          if (cur_cmd == CMD_NUKE) begin
            res_status <= ST_DONE;
            res_victim <= IDX_W'(rd_slot);
          end
        end else if (!last_pos) begin
          ptr <= ptr + SLOT_W'(1);
        end
      S_SHIFT:
        if (!last_pos) ptr <= ptr + SLOT_W'(1);
      default: ;
    endcase
  end

endmodule

FILE: hdl/lru_eviction_list_unit.sv
// lru replacement list over up to 16 slots, one command at a time
// flow: add, set pin, reload, ignored commands and a nuke refused for lack of budget go
//   straight from check to respond; remove, touch and nuke that find work walk the list
//   (search, then gap closing on a match), and a nuke with no victim only searches
// a new command is taken only in idle; the walk reads the
//   order list through its single port, one position per cycle, during search and gap closing
// reset (rst, synchronous): empties the list, clears all pins and the nuke budget, restores registers
module lru_eviction_list_unit import lru_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,   // entry_index[3:0], time_now[35:4], pin_value[36]
  input  logic [CMD_W-1:0]     s_axis_tuser,   // command[2:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // victim_index[3:0]
  output logic [STAT_W-1:0]    m_axis_tuser,   // status[1:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  // only slots reachable by a 4-bit index are kept
  localparam int SLOTS  = (ENTRIES < MAX_SLOTS) ? ENTRIES : MAX_SLOTS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  logic [TIME_W-1:0]   touch_interval;
  logic [BUDGET_W-1:0] budget_limit;
  ord_ctl_t            ord_ctl;
  logic [SLOT_W-1:0]   rd_slot;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    victim;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_interval <= TIME_W'(2);
      budget_limit   <= BUDGET_W'(50);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOUCH_INTERVAL: touch_interval <= cfg_data;
        CFG_BUDGET_LIMIT:   budget_limit <= cfg_data[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  lru_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_command     (s_axis_tuser),
    .in_entry_index (s_axis_tdata[3:0]),
    .in_time_now    (s_axis_tdata[35:4]),
    .in_pin_value   (s_axis_tdata[36]),
    .touch_interval (touch_interval),
    .budget_limit   (budget_limit),
    .ord_ctl        (ord_ctl),
    .rd_slot        (rd_slot),
    .count          (count),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_status     (m_axis_tuser),
    .out_victim     (victim)
  );

  lru_order #(.SLOTS(SLOTS)) u_order (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ord_ctl),
    .rd_slot (rd_slot),
    .count   (count)
  );

  assign m_axis_tdata = 8'(victim);

endmodule

FILE: hdl/lru_chk.sv
module lru_chk import lru_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [7:0]           m_axis_tdata,
  input logic [STAT_W-1:0]    m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one command in flight: no new transaction right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == 8'd0)
    else $error("victim set on a result that is not done");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind lru_eviction_list_unit lru_chk u_chk (.*);

FILE: test/lru_order_checker.sv
module lru_order_checker import lru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,   // entry_index[3:0], time_now[35:4], pin_value[36]
  input  logic [CMD_W-1:0]     s_axis_tuser,   // command[2:0]
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [7:0]           m_axis_tdata,   // victim_index[3:0]
  input  logic [STAT_W-1:0]    m_axis_tuser,   // status[1:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   replies_owed,
  output int                   evictions,
  output int                   budget_refusals
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  victim;
  } lru_reply_t;

  // oldest slot at the front of the queue
  logic [IDX_W-1:0]  age_order[$];
  logic              listed[MAX_SLOTS];
  logic [TIME_W-1:0] stamp[MAX_SLOTS];
  logic              pin_flag[MAX_SLOTS];
  logic [BUDGET_W-1:0] budget;
  logic [BUDGET_W-1:0] budget_reload;
  logic [TIME_W-1:0]   min_gap;
  lru_reply_t          replies_due[$];

  function automatic lru_reply_t step_lru_list(input logic [CMD_W-1:0] cmd,
                                               input logic [IDX_W-1:0] slot,
                                               input logic [TIME_W-1:0] now,
                                               input logic pin);
    lru_reply_t r;
    int pos;
    logic [TIME_W-1:0] age;
    r.status = ST_IGNORED;
    r.victim = '0;
    pos = -1;
    for (int i = 0; i < age_order.size() && pos < 0; i++)
      if (age_order[i] == slot) pos = i;
    age = now - stamp[slot];
    case (cmd)
      CMD_ADD: begin
        if (!listed[slot]) begin
          age_order.push_back(slot);
          listed[slot] = 1'b1;
          stamp[slot] = now;
          r.status = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        if (listed[slot]) begin
          if (pos >= 0) age_order.delete(pos);
          listed[slot] = 1'b0;
          r.status = ST_DONE;
        end
      end
      CMD_TOUCH: begin
        // elapsed ticks wrap modulo 2^32
        if (listed[slot] && age >= min_gap) begin
          if (pos >= 0) begin
            age_order.delete(pos);
            age_order.push_back(slot);
          end
          stamp[slot] = now;
          r.status = ST_DONE;
        end
      end
      CMD_PIN: begin
        pin_flag[slot] = pin;
        r.status = ST_DONE;
      end
      CMD_NUKE: begin
        if (budget == '0) begin
          r.status = ST_EXHAUSTED;
          budget_refusals++;
        end else begin
          // budget is spent even when no victim turns up
          budget = budget - BUDGET_W'(1);
          r.status = ST_NO_VICTIM;
          pos = -1;
          for (int i = 0; i < age_order.size() && pos < 0; i++)
            if (!pin_flag[age_order[i]]) pos = i;
          if (pos >= 0) begin
            r.victim = age_order[pos];
            age_order.delete(pos);
            age_order.push_back(r.victim);
            r.status = ST_DONE;
            evictions++;
          end
        end
      end
      CMD_RELOAD: begin
        budget = budget_reload;
        r.status = ST_DONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lru_reply_t want;
    if (rst) begin
      age_order.delete();
      replies_due.delete();
      for (int s = 0; s < MAX_SLOTS; s++) begin
        listed[s] = 1'b0;
        stamp[s] = '0;
        pin_flag[s] = 1'b0;
      end
      budget = '0;
      budget_reload = 8'd50;
      min_gap = 32'd2;
      fail_count = 0;
      replies_owed = 0;
      evictions = 0;
      budget_refusals = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction, expected none, got status %0d victim %0d",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tuser !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, m_axis_tuser);
          end
          if (m_axis_tdata !== 8'(want.victim)) begin
            fail_count++;
            $display("%0t: victim mismatch, expected %0d, got %0d",
                     $time, want.victim, m_axis_tdata);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOUCH_INTERVAL: min_gap = cfg_data;
          CFG_BUDGET_LIMIT:   budget_reload = cfg_data[BUDGET_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        replies_due.push_back(step_lru_list(s_axis_tuser, s_axis_tdata[IDX_W-1:0],
                                            s_axis_tdata[IDX_W +: TIME_W],
                                            s_axis_tdata[IDX_W+TIME_W]));
      replies_owed = replies_due.size();
    end
  end

endmodule

FILE: test/tb.sv
module tb;
  import lru_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD = 150;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata = '0;   // entry_index[3:0], time_now[35:4], pin_value[36]
  logic [CMD_W-1:0]     s_axis_tuser = '0;   // command[2:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // victim_index[3:0]
  logic [STAT_W-1:0]    m_axis_tuser;        // status[1:0]
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;

  int fail_count;
  int replies_owed;
  int evictions;
  int budget_refusals;

  int sent = 0;
  int settings = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int waited = 0;
  logic [TIME_W-1:0] clock_ticks = '0;

  always #6 clk = ~clk;

  lru_eviction_list_unit dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  lru_order_checker order_check (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .replies_owed, .evictions, .budget_refusals
  );

  // offers one command and returns at the falling edge after its transaction, or after a random idle gap
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] slot,
                       input logic [TIME_W-1:0] now, input logic pin);
    int gap;
    s_axis_tuser = cmd;
    s_axis_tdata = {3'b000, pin, now, slot};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // block is idle once every reply is in and the longest list walk is over
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [TIME_W-1:0] gap_ticks,
                              input logic [BUDGET_W-1:0] limit);
    cfg_we = 1'b1;
    cfg_index = CFG_TOUCH_INTERVAL;
    cfg_data = gap_ticks;
    @(negedge clk);
    cfg_index = CFG_BUDGET_LIMIT;
    cfg_data = TIME_W'(limit);
    @(negedge clk);
    cfg_we = 1'b0;
    settings++;
  endtask

  task automatic random_command();
    int roll;
    logic [IDX_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic pin;
    roll = $urandom_range(0, 99);
    slot = IDX_W'($urandom_range(0, MAX_SLOTS - 1));
    pin = 1'($urandom_range(0, 1));
    clock_ticks += TIME_W'($urandom_range(0, 3));
    now = ($urandom_range(0, 24) == 0) ? TIME_W'($urandom()) : clock_ticks;
    if (roll < 22) offer(CMD_ADD, slot, now, pin);
    else if (roll < 34) offer(CMD_REMOVE, slot, now, pin);
    else if (roll < 58) offer(CMD_TOUCH, slot, now, pin);
    else if (roll < 70) offer(CMD_PIN, slot, now, $urandom_range(0, 4) < 2);
    else if (roll < 90) offer(CMD_NUKE, slot, now, pin);
    else if (roll < 96) offer(CMD_RELOAD, slot, now, pin);
    else if (roll < 98) offer(CMD_SPARE_6, slot, now, pin);
    else offer(CMD_SPARE_7, slot, now, pin);
  endtask

  task automatic random_phase(input int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) hold_requests++;
      random_command();
    end
  endtask

  // result side: stall patterns of its own, plus long holds on request
  initial begin : sink
    int mode;
    int left;
    int hold;
    int served;
    mode = 0;
    left = 0;
    hold = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && served != hold_requests) begin
        served++;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 60);
        end
        left--;
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = ($urandom_range(0, 1) == 1);
          2: m_axis_tready = ($urandom_range(0, 7) != 0);
          default: m_axis_tready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    #(64'd12 * LIMIT_CYCLES);
    $display("lru_eviction_list_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // budget empty after reset, then an empty list
    offer(CMD_NUKE, 4'd0, 32'd0, 1'b0);
    offer(CMD_RELOAD, 4'd0, 32'd0, 1'b0);
    offer(CMD_NUKE, 4'd0, 32'd0, 1'b0);
    offer(CMD_ADD, 4'd0, 32'd100, 1'b0);
    offer(CMD_ADD, 4'd15, 32'd101, 1'b1);
    offer(CMD_ADD, 4'd0, 32'd102, 1'b0);
    offer(CMD_REMOVE, 4'd7, 32'd0, 1'b0);
    offer(CMD_TOUCH, 4'd7, 32'd200, 1'b0);
    offer(CMD_TOUCH, 4'd0, 32'd101, 1'b0);
    offer(CMD_TOUCH, 4'd0, 32'd102, 1'b0);
    offer(CMD_PIN, 4'd15, 32'd0, 1'b1);
    offer(CMD_PIN, 4'd3, 32'd0, 1'b1);
    // oldest is pinned, so the walk goes past it
    offer(CMD_NUKE, 4'd0, 32'd0, 1'b0);
    offer(CMD_PIN, 4'd0, 32'd0, 1'b1);
    offer(CMD_NUKE, 4'd0, 32'd0, 1'b0);
    offer(CMD_PIN, 4'd15, 32'd0, 1'b0);
    offer(CMD_PIN, 4'd0, 32'd0, 1'b0);
    offer(CMD_SPARE_6, 4'd1, 32'd5, 1'b1);
    offer(CMD_SPARE_7, 4'd2, 32'd6, 1'b0);
    offer(CMD_REMOVE, 4'd15, 32'd0, 1'b0);
    offer(CMD_REMOVE, 4'd15, 32'd0, 1'b0);
    // touch across the time wrap
    offer(CMD_ADD, 4'd15, 32'hFFFF_FFFF, 1'b0);
    offer(CMD_TOUCH, 4'd15, 32'd1, 1'b0);

    settle();
    program_regs(32'hFFFF_FFFF, 8'd0);
    offer(CMD_RELOAD, 4'd0, 32'd0, 1'b0);
    offer(CMD_NUKE, 4'd0, 32'd0, 1'b0);
    offer(CMD_ADD, 4'd9, 32'h8000_0000, 1'b0);
    offer(CMD_TOUCH, 4'd9, 32'h7FFF_FFFF, 1'b0);
    offer(CMD_TOUCH, 4'd9, 32'h8000_0000, 1'b0);

    random_phase(300);
    settle();
    program_regs(32'd0, 8'd255);
    random_phase(350);
    settle();
    program_regs(32'd5, 8'd3);
    clock_ticks = 32'hFFFF_FF00;
    random_phase(350);
    settle();
    program_regs(TIME_W'($urandom_range(1, 40)), BUDGET_W'($urandom_range(1, 12)));
    random_phase(350);
    settle();
    program_regs(32'd1, 8'd1);
    random_phase(300);
    settle();
    program_regs(32'd2, 8'd50);
    random_phase(350);

    s_axis_tvalid = 1'b0;
    while (replies_owed != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d commands over %0d register settings, %0d replies never arrived",
             sent, settings + 1, replies_owed);
    $display("nukes evicted %0d slots and were refused %0d times for lack of budget",
             evictions, budget_refusals);
    if (fail_count == 0 && replies_owed == 0)
      $display("lru_eviction_list_unit regression: pass");
    else
      $display("lru_eviction_list_unit regression: fail");
    $finish;
  end

endmodule
